@@ design/rks_pkg.sv @@
// Shared constants and types for the range k-th smallest unit.
package rks_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VALUE_BITS_DEF = 32;
	localparam int POS_W = 7;
	localparam int WORD_W = 32;
	localparam logic [POS_W-1:0] LEN_RESET = 7'd64;

	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic strobe;
		logic status;
		logic [WORD_W-1:0] value;
	} result_t;

endpackage

@@ design/rks_cell.sv @@
// One storage cell of the rotating value row.
module rks_cell #(
	parameter int VALUE_BITS = rks_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift,
	input  logic [VALUE_BITS-1:0] shift_in,
	input  logic                  wr_en,
	input  logic [VALUE_BITS-1:0] wr_data,
	output logic [VALUE_BITS-1:0] value
);

	logic [VALUE_BITS-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (wr_en) begin
			value_q <= wr_data;
		end else if (shift) begin
			value_q <= shift_in;
		end
	end

	assign value = value_q;

endmodule

@@ design/rks_search.sv @@
// Query checker and bit-by-bit rank search fed by the head of the cell row.
module rks_search #(
	parameter int DEPTH = rks_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = rks_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        query,
	input  logic [rks_pkg::POS_W-1:0]   left_pos,
	input  logic [rks_pkg::POS_W-1:0]   right_pos,
	input  logic [rks_pkg::POS_W-1:0]   rank,
	input  logic [rks_pkg::POS_W:0]     len,
	input  logic [VALUE_BITS-1:0]       head,
	output logic                        shift,
	output logic                        busy,
	output rks_pkg::result_t            result
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int BIT_W = $clog2(VALUE_BITS);
	localparam int PW = rks_pkg::POS_W;
	localparam int CMP_W = (IDX_W > PW ? IDX_W : PW) + 1;
	localparam logic [VALUE_BITS-1:0] SIGN_MASK = {1'b1, {(VALUE_BITS-1){1'b0}}};

	rks_pkg::state_t state_q, state_d;

	logic [PW-1:0]         lp0_q;
	logic [PW-1:0]         rp_q;
	logic [PW-1:0]         rank_q;
	logic [IDX_W-1:0]      step_q;
	logic [BIT_W-1:0]      bsel_q;
	logic [PW-1:0]         cnt_q;
	logic [VALUE_BITS-1:0] prefix_q;
	logic                  res_strobe_q;
	logic                  res_status_q;
	logic [rks_pkg::WORD_W-1:0] res_value_q;

	logic                  bad;
	logic                  in_range;
	logic                  hit;
	logic                  last_step;
	logic                  last_bit;
	logic                  keep_zero;
	logic [VALUE_BITS-1:0] key;
	logic [VALUE_BITS-1:0] cand;
	logic [VALUE_BITS-1:0] prefix_nx;
	logic [PW-1:0]         cnt_nx;
	logic signed [VALUE_BITS-1:0] ans_s;

	assign bad = (left_pos == '0) || (right_pos < left_pos)
		|| (CMP_W'(right_pos) > CMP_W'(len)) || (rank == '0)
		|| (({1'b0, rank} + {1'b0, left_pos}) > ({1'b0, right_pos} + (PW+1)'(1)));

	assign in_range = (CMP_W'(step_q) >= CMP_W'(lp0_q)) && (CMP_W'(step_q) < CMP_W'(rp_q));
	assign key = head ^ SIGN_MASK;
	assign cand = prefix_q | (VALUE_BITS'(1) << bsel_q);
	assign hit = in_range && (key < cand);
	assign cnt_nx = cnt_q + PW'(hit);
	assign last_step = (step_q == IDX_W'(DEPTH - 1));
	assign last_bit = (bsel_q == '0);
	assign keep_zero = (cnt_nx >= rank_q);
	assign prefix_nx = keep_zero ? prefix_q : cand;
	assign ans_s = signed'(prefix_nx ^ SIGN_MASK);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rks_pkg::ST_IDLE: begin
				if (query && !bad) begin
					state_d = rks_pkg::ST_SCAN;
				end
			end
			rks_pkg::ST_SCAN: begin
				if (last_step && last_bit) begin
					state_d = rks_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rks_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rks_pkg::ST_IDLE;
			res_strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_strobe_q <= (query && bad && state_q == rks_pkg::ST_IDLE)
				|| (state_q == rks_pkg::ST_SCAN && last_step && last_bit);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rks_pkg::ST_IDLE) begin
			if (query) begin
				lp0_q <= left_pos - PW'(1);
				rp_q <= right_pos;
				rank_q <= rank;
				step_q <= '0;
				bsel_q <= BIT_W'(VALUE_BITS - 1);
				cnt_q <= '0;
				prefix_q <= '0;
				res_status_q <= rks_pkg::STATUS_ERR;
				res_value_q <= '0;
			end
		end else begin
			if (last_step) begin
				step_q <= '0;
				cnt_q <= '0;
				prefix_q <= prefix_nx;
				bsel_q <= bsel_q - BIT_W'(1);
				if (last_bit) begin
					res_status_q <= rks_pkg::STATUS_OK;
					res_value_q <= rks_pkg::WORD_W'(ans_s);
				end
			end else begin
				step_q <= step_q + IDX_W'(1);
				cnt_q <= cnt_nx;
			end
		end
	end

	assign shift = (state_q == rks_pkg::ST_SCAN);
	assign busy = (state_q == rks_pkg::ST_SCAN);
	assign result.strobe = res_strobe_q;
	assign result.status = res_status_q;
	assign result.value = res_value_q;

endmodule

@@ design/range_kth_smallest_with_updates_unit.sv @@
// Range k-th smallest unit: rotating row of value cells with a rank search unit.
//
// A point write gives no word back. A query with a bad range or rank gives its
// word (status 1, value 0) in the cycle after it is taken. A good query holds busy
// high while, for each answer bit, the whole row of DEPTH cells rotates once past a
// single compare-and-count stage, and the word follows in the next cycle. Each
// result word is shown for one cycle only, marked by done; the receiver cannot
// stall it and must capture it on that cycle. The user must write the length
// register only while no query is in flight; the block itself does not
// enforce it.
module range_kth_smallest_with_updates_unit #(
	parameter int DEPTH = rks_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = rks_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              operation,
	input  logic [rks_pkg::POS_W-1:0]         position,
	input  logic [rks_pkg::POS_W-1:0]         left_pos,
	input  logic [rks_pkg::POS_W-1:0]         right_pos,
	input  logic [rks_pkg::POS_W-1:0]         rank,
	input  logic signed [rks_pkg::WORD_W-1:0] new_value,
	output logic                              done,
	output logic signed [rks_pkg::WORD_W-1:0] answer_value,
	output logic                              status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rks_pkg::POS_W-1:0]         cfg_data
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int PW = rks_pkg::POS_W;
	localparam int CMP_W = (IDX_W > PW ? IDX_W : PW) + 1;

	logic [PW-1:0]          array_length_q;
	logic [CMP_W-1:0]       len_wide;
	logic [PW:0]            len;
	logic                   accept;
	logic                   wr;
	logic                   query;
	logic [CMP_W-1:0]       wr_off;
	logic [IDX_W-1:0]       wr_idx;
	logic [VALUE_BITS-1:0]  wr_data;
	logic                   shift;
	logic [VALUE_BITS-1:0]  vals [DEPTH];
	rks_pkg::result_t       result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			array_length_q <= rks_pkg::LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			array_length_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	assign len_wide = (CMP_W'(array_length_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
		: CMP_W'(array_length_q);
	assign len = len_wide[PW:0];

	assign accept = start && !busy;
	assign query = accept && (operation == rks_pkg::OP_QUERY);
	assign wr = accept && (operation == rks_pkg::OP_WRITE) && (position != '0)
		&& (CMP_W'(position) <= len_wide);
	assign wr_off = CMP_W'(position) - CMP_W'(1);
	assign wr_idx = wr_off[IDX_W-1:0];
	assign wr_data = VALUE_BITS'(new_value);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam int NEXT = (i + 1) % DEPTH;
		rks_cell #(
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (shift),
			.shift_in (vals[NEXT]),
			.wr_en    (wr && (wr_idx == IDX_W'(i))),
			.wr_data  (wr_data),
			.value    (vals[i])
		);
	end

	rks_search #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.query     (query),
		.left_pos  (left_pos),
		.right_pos (right_pos),
		.rank      (rank),
		.len       (len),
		.head      (vals[0]),
		.shift     (shift),
		.busy      (busy),
		.result    (result)
	);

	assign done = result.strobe;
	assign status = result.status;
	assign answer_value = signed'(result.value);

endmodule

@@ verif/rks_answer_checker.sv @@
`timescale 1ns / 100ps
// Checker for the range k-th smallest unit: mirrors the array, predicts each query word, compares.
module rks_answer_checker
	import rks_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic                     operation,
	input  logic [POS_W-1:0]         position,
	input  logic [POS_W-1:0]         left_pos,
	input  logic [POS_W-1:0]         right_pos,
	input  logic [POS_W-1:0]         rank,
	input  logic signed [WORD_W-1:0] new_value,
	input  logic                     done,
	input  logic signed [WORD_W-1:0] answer_value,
	input  logic                     status,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [POS_W-1:0]         cfg_data,
	output int                       mismatches,
	output int                       outstanding
);

	typedef struct {
		logic signed [WORD_W-1:0] value;
		logic                     status;
	} answer_t;

	logic signed [WORD_W-1:0] cells [DEPTH_DEF];
	logic [POS_W-1:0] length_reg;
	answer_t answer_q [$];

	initial mismatches = 0;

	function automatic int used_length();
		return (length_reg > DEPTH_DEF) ? DEPTH_DEF : int'(length_reg);
	endfunction

	function automatic answer_t kth_in_range(input int lo, input int hi, input int k);
		answer_t a;
		int n_less;
		int n_leq;
		int i;
		int j;
		a.value = '0;
		a.status = STATUS_ERR;
		if (lo < 1 || hi < lo || hi > used_length() || k < 1 || k > hi - lo + 1)
			return a;
		for (i = lo - 1; i < hi; i++) begin
			n_less = 0;
			n_leq = 0;
			for (j = lo - 1; j < hi; j++) begin
				if (cells[j] < cells[i])
					n_less++;
				if (cells[j] <= cells[i])
					n_leq++;
			end
			if (n_less < k && k <= n_leq) begin
				a.value = cells[i];
				a.status = STATUS_OK;
				return a;
			end
		end
		return a;
	endfunction

	task automatic report(input string what);
		$display("check: %s at %0t", what, $realtime);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			foreach (cells[i])
				cells[i] = '0;
			length_reg = LEN_RESET;
			answer_q.delete();
			outstanding <= 0;
		end else begin
			if (done) begin
				if (answer_q.size() == 0) begin
					report($sformatf("unexpected word value %0d status %0b",
						answer_value, status));
				end else begin
					want = answer_q.pop_front();
					if (status !== want.status)
						report($sformatf("status %0b, want %0b", status, want.status));
					if (answer_value !== want.value)
						report($sformatf("value %0d, want %0d", answer_value, want.value));
				end
			end
			if (start && !busy) begin
				if (operation == OP_WRITE) begin
					if (position >= 1 && position <= used_length())
						cells[position - 1] = new_value;
				end else begin
					answer_q.insert(answer_q.size(),
						kth_in_range(int'(left_pos), int'(right_pos), int'(rank)));
				end
			end
			if (cfg_valid && cfg_ready)
				length_reg = cfg_data;
			outstanding <= answer_q.size();
		end
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the range k-th smallest unit: clock, reset, stimulus and verdict.
module tb;
	import rks_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic operation;
	logic [POS_W-1:0] position;
	logic [POS_W-1:0] left_pos;
	logic [POS_W-1:0] right_pos;
	logic [POS_W-1:0] rank;
	logic signed [WORD_W-1:0] new_value;
	logic done;
	logic signed [WORD_W-1:0] answer_value;
	logic status;
	logic cfg_valid;
	logic cfg_ready;
	logic [POS_W-1:0] cfg_data;
	int mismatches;
	int outstanding;
	int cycles;
	int len_now;
	bit idling;

	range_kth_smallest_with_updates_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.position(position),
		.left_pos(left_pos),
		.right_pos(right_pos),
		.rank(rank),
		.new_value(new_value),
		.done(done),
		.answer_value(answer_value),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	rks_answer_checker answers (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.position(position),
		.left_pos(left_pos),
		.right_pos(right_pos),
		.rank(rank),
		.new_value(new_value),
		.done(done),
		.answer_value(answer_value),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// drop start, hold until no word is owed and the unit is idle
	task automatic settle(input int hold);
		@(negedge clk);
		start = 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		repeat (hold) @(posedge clk);
	endtask

	task automatic send(input logic op, input int pos, input int lo, input int hi,
			input int k, input int val);
		@(negedge clk);
		while (idling && $urandom_range(0, 99) < 34) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		operation = op;
		position = POS_W'(pos);
		left_pos = POS_W'(lo);
		right_pos = POS_W'(hi);
		rank = POS_W'(k);
		new_value = val;
		do @(posedge clk); while (busy);
	endtask

	task automatic set_length(input int v);
		settle(4);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = POS_W'(v);
		len_now = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return $urandom;
		if (sel < 8)
			return int'($urandom_range(0, 8)) - 4;
		case ($urandom_range(0, 3))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return -1;
			default: return 0;
		endcase
	endfunction

	task automatic random_item();
		int eff;
		int sel;
		int lo;
		int hi;
		eff = (len_now > DEPTH_DEF) ? DEPTH_DEF : len_now;
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			if (eff > 0 && $urandom_range(0, 9) != 0)
				send(OP_WRITE, $urandom_range(1, eff), $urandom_range(0, 127),
					$urandom_range(0, 127), $urandom_range(0, 127), pick_value());
			else
				send(OP_WRITE, $urandom_range(0, 127), $urandom_range(0, 127),
					$urandom_range(0, 127), $urandom_range(0, 127), pick_value());
		end else if (sel < 90 && eff > 0) begin
			lo = $urandom_range(1, eff);
			hi = $urandom_range(lo, eff);
			send(OP_QUERY, $urandom_range(0, 127), lo, hi, $urandom_range(1, hi - lo + 1),
				$urandom);
		end else begin
			send(OP_QUERY, $urandom_range(0, 127), $urandom_range(0, 127),
				$urandom_range(0, 127), $urandom_range(0, 127), $urandom);
		end
	endtask

	task automatic run_random(input int n);
		repeat (n) begin
			if ($urandom_range(0, 24) == 0)
				settle(0);
			random_item();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_QUERY;
		position = '0;
		left_pos = '0;
		right_pos = '0;
		rank = '0;
		new_value = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idling = 1'b1;
		len_now = LEN_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(OP_WRITE, 1, 0, 0, 0, 32'h7FFFFFFF);
		send(OP_WRITE, 64, 0, 0, 0, 32'h80000000);
		send(OP_WRITE, 2, 0, 0, 0, -1);
		send(OP_WRITE, 3, 0, 0, 0, -1);
		send(OP_WRITE, 0, 0, 0, 0, 123);
		send(OP_WRITE, 127, 0, 0, 0, 55);
		send(OP_WRITE, 65, 0, 0, 0, 77);
		send(OP_QUERY, 0, 1, 64, 1, 0);
		send(OP_QUERY, 0, 1, 64, 64, 0);
		send(OP_QUERY, 0, 1, 3, 1, 0);
		send(OP_QUERY, 0, 1, 3, 2, 0);
		send(OP_QUERY, 0, 1, 3, 3, 0);
		send(OP_QUERY, 0, 0, 5, 1, 0);
		send(OP_QUERY, 0, 5, 4, 1, 0);
		send(OP_QUERY, 0, 1, 65, 1, 0);
		send(OP_QUERY, 0, 1, 64, 0, 0);
		send(OP_QUERY, 0, 2, 3, 3, 0);
		send(OP_QUERY, 0, 64, 64, 1, 0);
		send(OP_QUERY, 127, 127, 127, 127, -1);
		send(OP_QUERY, 0, 4, 63, 30, 0);

		set_length(0);
		send(OP_WRITE, 1, 0, 0, 0, 5);
		send(OP_QUERY, 0, 1, 1, 1, 0);
		run_random(6);
		set_length(1);
		run_random(20);
		set_length(127);
		idling = 1'b0;
		run_random(60);
		idling = 1'b1;
		set_length(9);
		run_random(60);
		set_length($urandom_range(2, 63));
		run_random(60);
		set_length(64);
		run_random(80);

		settle(16);
		if (mismatches == 0 && outstanding == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
